@@ design/sitoa_pkg.sv @@
// Shared constants, types and the binary-to-BCD step function for the decimal text converter.
package sitoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIGITS      = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int IDX_W       = $clog2(DIGITS);
    localparam int STEP_BITS   = 8;
    localparam int NUM_STAGES  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [VALUE_WIDTH-1:0] mag_t;
    typedef logic [BCD_W-1:0]       bcd_t;
    typedef logic [IDX_W-1:0]       idx_t;

    typedef struct packed {
        bcd_t bcd;
        mag_t mag;
    } dabble_t;

    function automatic dabble_t dabble(input bcd_t bcd_in, input mag_t mag_in,
                                       input int nsteps);
        dabble_t res;
        bcd_t    b;
        mag_t    m;
        b = bcd_in;
        m = mag_in;
        for (int i = 0; i < STEP_BITS; i++) begin
            if (i < nsteps) begin
                for (int d = 0; d < DIGITS; d++) begin
                    if (b[4*d +: 4] >= 4'd5) begin
                        b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                    end
                end
                b = {b[BCD_W-2:0], m[VALUE_WIDTH-1]};
                m = {m[VALUE_WIDTH-2:0], 1'b0};
            end
        end
        res.bcd = b;
        res.mag = m;
        return res;
    endfunction

endpackage

@@ design/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII text: magnitude stage, pipelined BCD conversion, serializer.
// Throughput: one character per cycle while out_ready lets the output move; the pipeline
//   can accept new values while an earlier value is still being serialized.
//   A value's text has 1 to 11 characters at 32 bits, sent through the single-character
//   output port.
// Reset: asynchronous, active low; clears all valid bits and the serializer, no clearing pass.
module signed_int_to_decimal_ascii (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [sitoa_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           character,
    output logic                                 last_char
);

    localparam int NST = sitoa_pkg::NUM_STAGES;

    logic              stg_valid [0:NST];
    logic              stg_neg   [0:NST];
    sitoa_pkg::mag_t   stg_mag   [0:NST];
    sitoa_pkg::bcd_t   stg_bcd   [0:NST];
    logic              stg_rdy   [0:NST];
    logic              ser_take;

    // magnitude stage
    logic            s0_valid_reg;
    logic            s0_neg_reg;
    sitoa_pkg::mag_t s0_mag_reg;

    assign stg_rdy[0] = !s0_valid_reg || stg_rdy[1];
    assign in_ready   = stg_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (stg_rdy[0])
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[0] && in_valid)
        begin
            s0_neg_reg <= value[sitoa_pkg::VALUE_WIDTH-1];
            s0_mag_reg <= value[sitoa_pkg::VALUE_WIDTH-1] ? sitoa_pkg::mag_t'(-value)
                                                         : sitoa_pkg::mag_t'(value);
        end
    end

    assign stg_valid[0] = s0_valid_reg;
    assign stg_neg[0]   = s0_neg_reg;
    assign stg_mag[0]   = s0_mag_reg;
    assign stg_bcd[0]   = '0;

    // BCD conversion stages, STEP_BITS shift-and-add steps each
    for (genvar j = 0; j < NST; j++)
    begin : g_dabble
        localparam int REM   = sitoa_pkg::VALUE_WIDTH - j * sitoa_pkg::STEP_BITS;
        localparam int STEPS = (REM < sitoa_pkg::STEP_BITS) ? REM : sitoa_pkg::STEP_BITS;

        logic               valid_reg;
        logic               neg_reg;
        sitoa_pkg::mag_t    mag_reg;
        sitoa_pkg::bcd_t    bcd_reg;
        sitoa_pkg::dabble_t step_next;
        logic               rdy_next;

        assign step_next = sitoa_pkg::dabble(stg_bcd[j], stg_mag[j], STEPS);

        if (j == NST - 1)
        begin : g_tail
            assign rdy_next = ser_take;
        end
        else
        begin : g_mid
            assign rdy_next = stg_rdy[j+2];
        end

        assign stg_rdy[j+1] = !valid_reg || rdy_next;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (stg_rdy[j+1])
            begin
                valid_reg <= stg_valid[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_rdy[j+1] && stg_valid[j])
            begin
                neg_reg <= stg_neg[j];
                mag_reg <= step_next.mag;
                bcd_reg <= step_next.bcd;
            end
        end

        assign stg_valid[j+1] = valid_reg;
        assign stg_neg[j+1]   = neg_reg;
        assign stg_mag[j+1]   = mag_reg;
        assign stg_bcd[j+1]   = bcd_reg;
    end

    // serializer and output register
    logic            ser_busy_reg;
    logic            ser_minus_reg;
    sitoa_pkg::idx_t ser_idx_reg;
    sitoa_pkg::bcd_t ser_bcd_reg;
    logic            out_valid_reg;
    logic [7:0]      char_reg;
    logic            last_reg;

    sitoa_pkg::idx_t lead;
    logic            emit;
    logic            done;
    logic [3:0]      digit;
    logic [7:0]      char_next;
    logic            last_next;

    always_comb
    begin
        lead = '0;
        for (int d = 0; d < sitoa_pkg::DIGITS; d++)
        begin
            if (stg_bcd[NST][4*d +: 4] != 4'd0)
            begin
                lead = sitoa_pkg::idx_t'(d);
            end
        end
    end

    assign emit     = ser_busy_reg && (!out_valid_reg || out_ready);
    assign done     = emit && !ser_minus_reg && (ser_idx_reg == '0);
    assign ser_take = !ser_busy_reg || done;
    assign digit    = ser_bcd_reg[{ser_idx_reg, 2'b00} +: 4];

    always_comb
    begin
        if (ser_minus_reg)
        begin
            char_next = sitoa_pkg::CHAR_MINUS;
            last_next = 1'b0;
        end
        else
        begin
            char_next = sitoa_pkg::CHAR_ZERO + {4'b0000, digit};
            last_next = (ser_idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_busy_reg  <= 1'b0;
            ser_minus_reg <= 1'b0;
            ser_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ser_take && stg_valid[NST])
            begin
                ser_busy_reg  <= 1'b1;
                ser_minus_reg <= stg_neg[NST];
                ser_idx_reg   <= lead;
            end
            else if (done)
            begin
                ser_busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                if (ser_minus_reg)
                begin
                    ser_minus_reg <= 1'b0;
                end
                else
                begin
                    ser_idx_reg <= ser_idx_reg - 1'b1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take && stg_valid[NST])
        begin
            ser_bcd_reg <= stg_bcd[NST];
        end
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_busy_reg |-> (ser_idx_reg < sitoa_pkg::IDX_W'(sitoa_pkg::DIGITS)))
        else $error("serializer digit index out of range");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((char_reg == sitoa_pkg::CHAR_MINUS) ||
                           ((char_reg >= sitoa_pkg::CHAR_ZERO) &&
                            (char_reg <= sitoa_pkg::CHAR_NINE))))
        else $error("output character is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == sitoa_pkg::CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign marked as last character");

    a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ser_minus_reg) |=> (ser_busy_reg && !ser_minus_reg))
        else $error("serializer dropped digits after minus sign");

endmodule

@@ test/signed_int_to_decimal_ascii_tb.sv @@
// Testbench for signed_int_to_decimal_ascii: random handshakes, predicted character stream.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

    localparam int W = sitoa_pkg::VALUE_WIDTH;

    typedef logic signed [W-1:0] value_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } glyph_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_ready;
    value_t value     = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic [7:0] character;
    logic   last_char;

    value_t values_to_send[$];
    glyph_t pending_text[$];
    glyph_t due;

    int total_values = 0;
    int values_taken = 0;
    int mismatches   = 0;
    int send_gap     = 0;
    int send_calm    = 0;
    int take_gap     = 0;
    int take_calm    = 0;
    int squeeze_left = 0;
    int next_squeeze = 60;

    signed_int_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last_char (last_char)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int idle_len(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void spell_decimal(input value_t v);
        logic [W-1:0] mag;
        logic [3:0]   digits [0:19];
        glyph_t       g;
        int           nd;
        mag = v[W-1] ? (~v + 1'b1) : v;
        nd  = 0;
        while (nd == 0 || mag != 0)
        begin
            digits[nd] = 4'(mag % 10);
            mag        = mag / 10;
            nd++;
        end
        if (v[W-1])
        begin
            g.code = sitoa_pkg::CHAR_MINUS;
            g.last = 1'b0;
            pending_text.push_back(g);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            g.code = sitoa_pkg::CHAR_ZERO + 8'(digits[i]);
            g.last = (i == 0);
            pending_text.push_back(g);
        end
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                spell_decimal(value);
                values_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (values_to_send.size() > 0)
                begin
                    value    <= values_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = idle_len(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_text.size() == 0)
                begin
                    note_mismatch("unexpected transaction, character", -1, character);
                end
                else
                begin
                    due = pending_text.pop_front();
                    if (character !== due.code)
                        note_mismatch("character", due.code, character);
                    if (last_char !== due.last)
                        note_mismatch("last_char", due.last, last_char);
                end
            end
            if (values_taken >= next_squeeze)
            begin
                squeeze_left = 200;
                next_squeeze += 250;
            end
            if (squeeze_left > 0)
            begin
                squeeze_left--;
                out_ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                take_gap = idle_len(take_calm);
            end
        end
    end

    initial
    begin
        longint lo;
        longint hi;
        longint mag;
        int     d;
        int     pick;

        values_to_send.push_back(0);
        values_to_send.push_back(1);
        values_to_send.push_back(-1);
        values_to_send.push_back(9);
        values_to_send.push_back(10);
        values_to_send.push_back(-9);
        values_to_send.push_back(-10);
        values_to_send.push_back(99);
        values_to_send.push_back(100);
        values_to_send.push_back(32'sh7FFF_FFFF);
        values_to_send.push_back(32'sh8000_0000);
        values_to_send.push_back(32'sh8000_0001);
        values_to_send.push_back(1000000000);
        values_to_send.push_back(-1000000000);
        values_to_send.push_back(999999999);
        values_to_send.push_back(1999999999);
        values_to_send.push_back(32'sh5555_5555);
        values_to_send.push_back(32'shAAAA_AAAA);
        values_to_send.push_back(12345);
        values_to_send.push_back(-7);
        values_to_send.push_back(0);

        for (int n = 0; n < 449; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                values_to_send.push_back(value_t'($urandom));
            end
            else if (pick < 8)
            begin
                d  = $urandom_range(1, 10);
                lo = 1;
                repeat (d - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 2147483647)
                    hi = 2147483647;
                mag = lo + longint'($urandom) % (hi - lo + 1);
                if ($urandom_range(0, 1))
                    mag = -mag;
                values_to_send.push_back(value_t'(mag));
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                values_to_send.push_back(32'sh8000_0000);
            end
            else
            begin
                d  = $urandom_range(0, 9);
                lo = 1;
                repeat (d) lo = lo * 10;
                mag = lo - $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    mag = -mag;
                values_to_send.push_back(value_t'(mag));
            end
        end
        total_values = values_to_send.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (values_taken < total_values || pending_text.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/sitoa_pkg.sv
design/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_tb.sv
